// ===== sv/lowest_common_ancestor_lifting_unit_macros.svh =====
// assertion macros shared by the checker files of the lifting unit
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_UNIT_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LCAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcal check failed");

// next-cycle implication, sampled on clk, off during rst
`define LCAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcal check failed");

`endif

// ===== sv/lcal_pkg.sv =====
// types and fixed constants of the lifting unit
`default_nettype none

package lcal_pkg;

  localparam int NODE_FW  = 10;                // node field width
  localparam int DEPTH_FW = 10;                // stored depth width
  localparam int DIST_FW  = 11;                // distance field width
  localparam int ALU_W    = 18;                // shared unit width, signed
  localparam int STEP_W   = $clog2(NODE_FW);   // reduction step counter

  localparam logic [DIST_FW-1:0] DIST_MAX = 11'd2046;

  // item opcodes
  localparam logic OP_ATTACH = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // shared unit operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [NODE_FW-1:0]  node_a;
    logic [NODE_FW-1:0]  node_b;
  } req_t;

  typedef struct packed {
    logic [NODE_FW-1:0]  ancestor;
    logic [DIST_FW-1:0]  distance;
  } rsp_t;

  typedef struct packed {
    logic              op;
    logic [ALU_W-1:0]  x;
    logic [ALU_W-1:0]  y;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]  sum;
    logic              neg;
    logic              eq;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== sv/lcal_ram.sv =====
// generic ram, one write port and one registered read port
`default_nettype none

module lcal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lcal_alu.sv =====
// shared add, subtract and compare unit of the lifting unit
`default_nettype none

module lcal_alu (
  input  lcal_pkg::alu_req_t req,
  output lcal_pkg::alu_res_t res
);

  logic [lcal_pkg::ALU_W-1:0] addend;
  logic                       carry;

  always_comb begin
    carry   = (req.op == lcal_pkg::ALU_SUB);
    addend  = carry ? ~req.y : req.y;
    res.sum = req.x + addend + {{(lcal_pkg::ALU_W-1){1'b0}}, carry};
    res.neg = res.sum[lcal_pkg::ALU_W-1];
    res.eq  = (req.x == req.y);
  end

endmodule

`default_nettype wire

// ===== sv/lowest_common_ancestor_lifting_unit.sv =====
// binary lifting lowest common ancestor unit: ancestor ram, depth ram, one shared alu
// attach: level 0 is written first, then each higher level is read and written in turn
// query: pass 1 lifts the deeper node (ancestor read, depth read, compare per level); pass 2
// lifts both nodes and is skipped when they meet early; an unread result holds the last step
// when NODES is not a power of two below 1024, the S_MOD steps first reduce the node indices
// rst clears the sequencer and the result valid flag; table contents stay undefined until written
`default_nettype none

module lowest_common_ancestor_lifting_unit #(
  parameter int NODES      = 1024,
  parameter int LOG_LEVELS = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lcal_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lcal_pkg::rsp_t   rsp
);

  // widths
  localparam int IW   = $clog2(NODES);        // node index
  localparam int LW   = $clog2(LOG_LEVELS);   // level index
  localparam int FW   = lcal_pkg::NODE_FW;
  localparam int DW   = lcal_pkg::DEPTH_FW;
  localparam int AW   = lcal_pkg::ALU_W;
  localparam int KW   = lcal_pkg::STEP_W;
  localparam int DSTW = lcal_pkg::DIST_FW;
  localparam int ANW  = LW + IW;              // ancestor ram address: {level, node}

  localparam int ANC_DEPTH = LOG_LEVELS * (2 ** IW);

  // field values must be reduced modulo NODES unless a plain truncation does it
  localparam bit MOD_NEEDED = (NODES < (2 ** FW)) && ((NODES & (NODES - 1)) != 0);

  localparam logic [LW-1:0] LVL_TOP   = LW'(LOG_LEVELS - 1);
  localparam logic [LW-1:0] LVL_ONE   = LW'(1);
  localparam logic [LW-1:0] LVL_ZERO  = '0;
  localparam logic [KW-1:0] STEP_TOP  = KW'(FW - 1);
  localparam logic [KW-1:0] STEP_ONE  = KW'(1);
  localparam logic [AW-1:0] NODES_A   = AW'(NODES);
  localparam logic [AW-1:0] ONE_A     = AW'(1);
  localparam logic [DW-1:0] DEPTH_SAT = '1;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_MOD      = 5'd1;   // restoring reduction of the node fields
  localparam logic [4:0] S_LOAD     = 5'd2;
  localparam logic [4:0] S_ATT_ROOT = 5'd3;   // root check, level 0 write, parent depth read
  localparam logic [4:0] S_ATT_DEP  = 5'd4;   // child depth write, first level read
  localparam logic [4:0] S_ATT_WR   = 5'd5;
  localparam logic [4:0] S_ATT_RD   = 5'd6;
  localparam logic [4:0] S_Q_RDA    = 5'd7;
  localparam logic [4:0] S_Q_RDB    = 5'd8;
  localparam logic [4:0] S_Q_SWAP   = 5'd9;   // deeper node goes to a
  localparam logic [4:0] S_P1_ANC   = 5'd10;
  localparam logic [4:0] S_P1_DEP   = 5'd11;
  localparam logic [4:0] S_P1_CMP   = 5'd12;
  localparam logic [4:0] S_Q_EQ     = 5'd13;
  localparam logic [4:0] S_P2_RA    = 5'd14;
  localparam logic [4:0] S_P2_RB    = 5'd15;
  localparam logic [4:0] S_P2_CMP   = 5'd16;
  localparam logic [4:0] S_F_RA     = 5'd17;
  localparam logic [4:0] S_F_LAT    = 5'd18;
  localparam logic [4:0] S_F_DREQ   = 5'd19;
  localparam logic [4:0] S_F_DL     = 5'd20;
  localparam logic [4:0] S_D_SUM    = 5'd21;
  localparam logic [4:0] S_D_SUB1   = 5'd22;
  localparam logic [4:0] S_D_SUB2   = 5'd23;

  logic [4:0]    state, state_next;

  // item registers
  logic          op;
  logic [FW-1:0] ra, rb;        // raw fields during reduction
  logic          msel;          // reduction works on rb when set
  logic [KW-1:0] kcnt;          // reduction shift
  logic [IW-1:0] a, b;          // working nodes
  logic [IW-1:0] p;             // latched ancestor (parent walk, pass 1 and pass 2)
  logic [IW-1:0] lca;
  logic [LW-1:0] lvl;
  logic          root;
  logic [DW-1:0] da, db, dsh, dl;
  logic [AW-1:0] acc;           // distance accumulator

  // ram ports
  logic            anc_we;
  logic [ANW-1:0]  anc_waddr, anc_raddr;
  logic [IW-1:0]   anc_wdata, anc_rdata;
  logic            dep_we;
  logic [IW-1:0]   dep_raddr;
  logic [DW-1:0]   dep_wdata, dep_rdata;

  lcal_pkg::alu_req_t alu_req;
  lcal_pkg::alu_res_t alu_res;

  logic [LW-1:0] lvl_dn;
  logic          rsp_free;
  logic          rsp_load;
  logic          start_op;
  logic [4:0]    start_state;
  logic [FW-1:0] mod_r, mod_new;

  assign req_ready = (state == S_IDLE);
  assign lvl_dn    = lvl - LVL_ONE;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // ancestor table: LOG_LEVELS rows of node entries
  lcal_ram #(
    .WIDTH (IW),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  // depth table, written only at the child of an attach
  lcal_ram #(
    .WIDTH (DW),
    .DEPTH (NODES)
  ) u_dep_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (a),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  lcal_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // first state of the item's own work
  always_comb begin
    start_op    = (state == S_IDLE) ? req.opcode : op;
    start_state = S_ATT_ROOT;
    case (start_op)
      lcal_pkg::OP_ATTACH: start_state = S_ATT_ROOT;
      lcal_pkg::OP_QUERY:  start_state = S_Q_RDA;
    endcase
  end

  // one reduction step: subtract NODES << kcnt when it fits
  always_comb begin
    mod_r   = msel ? rb : ra;
    mod_new = FW'(alu_res.sum << kcnt) | (mod_r & ~({FW{1'b1}} << kcnt));
  end

  // sequencer: next state, ram ports, shared unit operands
  always_comb begin
    state_next  = state;
    anc_we      = 1'b0;
    anc_waddr   = {lvl, a};
    anc_wdata   = anc_rdata;
    anc_raddr   = {lvl, a};
    dep_we      = 1'b0;
    dep_wdata   = '0;
    dep_raddr   = a;
    rsp_load    = 1'b0;
    alu_req.op  = lcal_pkg::ALU_SUB;
    alu_req.x   = AW'(a);
    alu_req.y   = AW'(b);

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = MOD_NEEDED ? S_MOD : start_state;
        end
      end
      S_MOD: begin
        alu_req.x = AW'(mod_r >> kcnt);
        alu_req.y = NODES_A;
        if (msel && (kcnt == '0)) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = start_state;
      end
      S_ATT_ROOT: begin
        // level 0 is the parent itself; eq flags a root attach
        anc_we     = 1'b1;
        anc_waddr  = {LVL_ZERO, a};
        anc_wdata  = b;
        dep_raddr  = b;
        state_next = S_ATT_DEP;
      end
      S_ATT_DEP: begin
        alu_req.op = lcal_pkg::ALU_ADD;
        alu_req.x  = AW'(dep_rdata);
        alu_req.y  = ONE_A;
        dep_we     = 1'b1;
        if (root) begin
          dep_wdata = '0;
        end else if (alu_res.sum[DW]) begin
          dep_wdata = DEPTH_SAT;
        end else begin
          dep_wdata = alu_res.sum[DW-1:0];
        end
        anc_raddr  = {lvl_dn, p};
        state_next = S_ATT_WR;
      end
      S_ATT_WR: begin
        anc_we     = 1'b1;
        anc_waddr  = {lvl, a};
        anc_wdata  = anc_rdata;
        state_next = (lvl == LVL_TOP) ? S_IDLE : S_ATT_RD;
      end
      S_ATT_RD: begin
        anc_raddr  = {lvl_dn, p};
        state_next = S_ATT_WR;
      end
      S_Q_RDA: begin
        dep_raddr  = a;
        state_next = S_Q_RDB;
      end
      S_Q_RDB: begin
        dep_raddr  = b;
        state_next = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        alu_req.x  = AW'(da);
        alu_req.y  = AW'(dep_rdata);
        state_next = S_P1_ANC;
      end
      S_P1_ANC: begin
        anc_raddr  = {lvl, a};
        state_next = S_P1_DEP;
      end
      S_P1_DEP: begin
        dep_raddr  = anc_rdata;
        state_next = S_P1_CMP;
      end
      S_P1_CMP: begin
        alu_req.x  = AW'(dep_rdata);
        alu_req.y  = AW'(dsh);
        state_next = (lvl == LVL_ZERO) ? S_Q_EQ : S_P1_ANC;
      end
      S_Q_EQ: begin
        state_next = alu_res.eq ? S_F_DREQ : S_P2_RA;
      end
      S_P2_RA: begin
        anc_raddr  = {lvl, a};
        state_next = S_P2_RB;
      end
      S_P2_RB: begin
        anc_raddr  = {lvl, b};
        state_next = S_P2_CMP;
      end
      S_P2_CMP: begin
        alu_req.x  = AW'(p);
        alu_req.y  = AW'(anc_rdata);
        state_next = (lvl == LVL_ZERO) ? S_F_RA : S_P2_RA;
      end
      S_F_RA: begin
        anc_raddr  = {LVL_ZERO, a};
        state_next = S_F_LAT;
      end
      S_F_LAT: begin
        state_next = S_F_DREQ;
      end
      S_F_DREQ: begin
        dep_raddr  = lca;
        state_next = S_F_DL;
      end
      S_F_DL: begin
        state_next = S_D_SUM;
      end
      S_D_SUM: begin
        alu_req.op = lcal_pkg::ALU_ADD;
        alu_req.x  = AW'(da);
        alu_req.y  = AW'(db);
        state_next = S_D_SUB1;
      end
      S_D_SUB1: begin
        alu_req.x  = acc;
        alu_req.y  = AW'(dl);
        state_next = S_D_SUB2;
      end
      S_D_SUB2: begin
        // wait here while the previous result is still unread
        alu_req.x = acc;
        alu_req.y = AW'(dl);
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      lvl       <= '0;
      kcnt      <= '0;
      msel      <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          kcnt <= STEP_TOP;
          msel <= 1'b0;
        end
        S_MOD: begin
          msel <= !msel;
          if (msel) begin
            kcnt <= kcnt - STEP_ONE;
          end
        end
        S_ATT_ROOT: lvl <= LVL_ONE;
        S_ATT_WR:   lvl <= lvl + LVL_ONE;
        S_Q_SWAP:   lvl <= LVL_TOP;
        S_P1_CMP:   lvl <= lvl_dn;
        S_Q_EQ:     lvl <= LVL_TOP;
        S_P2_CMP:   lvl <= lvl_dn;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op <= req.opcode;
          ra <= req.node_a;
          rb <= req.node_b;
          a  <= IW'(req.node_a);
          b  <= IW'(req.node_b);
        end
      end
      S_MOD: begin
        if (!alu_res.neg) begin
          if (msel) begin
            rb <= mod_new;
          end else begin
            ra <= mod_new;
          end
        end
      end
      S_LOAD: begin
        a <= IW'(ra);
        b <= IW'(rb);
      end
      S_ATT_ROOT: begin
        root <= alu_res.eq;
        p    <= b;
      end
      S_ATT_WR: p <= anc_rdata;
      S_Q_RDB:  da <= dep_rdata;
      S_Q_SWAP: begin
        db <= dep_rdata;
        if (alu_res.neg) begin
          a   <= b;
          b   <= a;
          dsh <= da;
        end else begin
          dsh <= dep_rdata;
        end
      end
      S_P1_DEP: p <= anc_rdata;
      S_P1_CMP: begin
        // lift when the ancestor is not above the shallower node
        if (!alu_res.neg) begin
          a <= p;
        end
      end
      S_Q_EQ:   lca <= a;
      S_P2_RB:  p <= anc_rdata;
      S_P2_CMP: begin
        if (!alu_res.eq) begin
          a <= p;
          b <= anc_rdata;
        end
      end
      S_F_LAT:  lca <= anc_rdata;
      S_F_DL:   dl <= dep_rdata;
      S_D_SUM:  acc <= alu_res.sum;
      S_D_SUB1: acc <= alu_res.sum;
      S_D_SUB2: begin
        if (rsp_free) begin
          rsp.ancestor <= FW'(lca);
          rsp.distance <= alu_res.neg ? '0 : DSTW'(alu_res.sum);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lcal_checker.sv =====
// port checker of the lifting unit and its bind
`default_nettype none
`include "lowest_common_ancestor_lifting_unit_macros.svh"

module lcal_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input lcal_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lcal_pkg::rsp_t rsp
);

  // the block is not ready again in the cycle after it accepts an item
  `LCAL_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  // an attach never brings a result
  `LCAL_ASSERT_NEXT(a_attach_silent, req_valid && req_ready && (req.opcode == lcal_pkg::OP_ATTACH), !$rose(rsp_valid))

  // two depths of at most 1023 bound the distance
  `LCAL_ASSERT_NOW(a_distance_range, rsp_valid, rsp.distance <= lcal_pkg::DIST_MAX)

  // a waiting result holds
  `LCAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind lowest_common_ancestor_lifting_unit lcal_checker u_lcal_checker (.*);

`default_nettype wire

// ===== bench/tb_lowest_common_ancestor_lifting_unit.sv =====
// self-checking bench for the binary lifting lowest common ancestor unit
`default_nettype none

module tb_lowest_common_ancestor_lifting_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT  = 1024;
  localparam int LIFT_LEVELS = 11;
  // nodes in the long chain of the last phase
  localparam int CHAIN_LEN   = 128;
  // slowest query: both passes over every level plus overhead
  localparam int QUERY_TAIL  = 6 * LIFT_LEVELS + 20;

  // ---------------------------------------------------------------------------
  // ancestry tracker: mirrors the jump table and depth table, predicts the
  // answer of every accepted query and compares it with what comes back
  // ---------------------------------------------------------------------------
  class ancestry_model;
    localparam logic [lcal_pkg::DEPTH_FW-1:0] DEPTH_TOP = '1;

    logic [lcal_pkg::NODE_FW-1:0]  jump [LIFT_LEVELS][NODE_COUNT];
    logic [lcal_pkg::DEPTH_FW-1:0] level_of [NODE_COUNT];
    lcal_pkg::rsp_t                answers_due [$];
    int                            mismatches;

    function new();
      foreach (jump[i, n]) jump[i][n] = '0;
      foreach (level_of[n]) level_of[n] = '0;
      mismatches = 0;
    endfunction

    function logic [lcal_pkg::NODE_FW-1:0] common_ancestor_of(
        logic [lcal_pkg::NODE_FW-1:0] a, logic [lcal_pkg::NODE_FW-1:0] b);
      logic [lcal_pkg::NODE_FW-1:0] x, y, px, py;
      x = a;
      y = b;
      // x is always the deeper one
      if (level_of[x] < level_of[y]) begin
        x = b;
        y = a;
      end
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
        px = jump[i][x];
        if (level_of[px] >= level_of[y]) x = px;
      end
      if (x == y) return x;
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
        px = jump[i][x];
        py = jump[i][y];
        if (px != py) begin
          x = px;
          y = py;
        end
      end
      return jump[0][x];
    endfunction

    function void note_item(lcal_pkg::req_t it);
      logic [lcal_pkg::NODE_FW-1:0] lca;
      int                           spread;
      lcal_pkg::rsp_t               due;
      if (it.opcode == lcal_pkg::OP_ATTACH) begin
        if (it.node_a == it.node_b) begin
          level_of[it.node_a] = '0;
        end else if (level_of[it.node_b] == DEPTH_TOP) begin
          level_of[it.node_a] = DEPTH_TOP;
        end else begin
          level_of[it.node_a] = level_of[it.node_b] + 1'b1;
        end
        jump[0][it.node_a] = it.node_b;
        for (int i = 1; i < LIFT_LEVELS; i++)
          jump[i][it.node_a] = jump[i-1][jump[i-1][it.node_a]];
      end else begin
        lca    = common_ancestor_of(it.node_a, it.node_b);
        spread = int'(level_of[it.node_a]) + int'(level_of[it.node_b])
                 - 2 * int'(level_of[lca]);
        if (spread < 0) spread = 0;
        due.ancestor = lca;
        due.distance = spread[lcal_pkg::DIST_FW-1:0];
        answers_due = {answers_due, due};
      end
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_answer(lcal_pkg::rsp_t got);
      lcal_pkg::rsp_t want;
      if (answers_due.size() == 0) begin
        flag_mismatch($sformatf("answer with none pending (ancestor %0d distance %0d)",
                                got.ancestor, got.distance));
        return;
      end
      want = answers_due.pop_front();
      if (got.ancestor !== want.ancestor)
        flag_mismatch($sformatf("ancestor %0d, predicted %0d", got.ancestor, want.ancestor));
      if (got.distance !== want.distance)
        flag_mismatch($sformatf("distance %0d, predicted %0d", got.distance, want.distance));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and the block itself
  // ---------------------------------------------------------------------------
  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           rsp_ready = 1'b0;
  lcal_pkg::req_t req       = '0;
  logic           req_ready;
  logic           rsp_valid;
  lcal_pkg::rsp_t rsp;

  // idle odds in percent, changed per phase
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;

  ancestry_model model = new();

  // nodes attached so far; queries and parents are drawn only from these
  bit placed [NODE_COUNT];
  int placed_nodes [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lowest_common_ancestor_lifting_unit #(
    .NODES      (NODE_COUNT),
    .LOG_LEVELS (LIFT_LEVELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // answer side: check on the handshake, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) model.check_answer(rsp);
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  // ---------------------------------------------------------------------------
  // item drivers
  // ---------------------------------------------------------------------------

  // presents one item and holds it until the block takes it;
  // valid is only dropped by an idle gap, so back-to-back items keep it high
  task automatic send_item(input logic op, input int a, input int b);
    lcal_pkg::req_t it;
    it.opcode = op;
    it.node_a = a[lcal_pkg::NODE_FW-1:0];
    it.node_b = b[lcal_pkg::NODE_FW-1:0];
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    model.note_item(it);
    items_sent++;
  endtask

  // child under parent; child equal to parent makes a root
  task automatic hang_node(input int child, input int parent);
    send_item(lcal_pkg::OP_ATTACH, child, parent);
    if (!placed[child]) begin
      placed[child] = 1'b1;
      placed_nodes = {placed_nodes, child};
    end
  endtask

  task automatic ask_pair(input int a, input int b);
    send_item(lcal_pkg::OP_QUERY, a, b);
  endtask

  function automatic int any_placed();
    return placed_nodes[$urandom_range(placed_nodes.size() - 1)];
  endfunction

  // hold the sender back until every pending answer is in
  task automatic settle_answers();
    req_valid <= 1'b0;
    @(posedge clk);
    while (model.answers_due.size() != 0) @(posedge clk);
  endtask

  // one fresh tree of random nodes, grown mostly as deep chains, with queries
  // between its members mixed in; a few items are noise across all trees:
  // stray queries and reattachments that leave stale depths behind
  task automatic tree_burst();
    int members [$];
    bit in_burst [NODE_COUNT];
    int len, roll, child, parent, root;
    root = $urandom_range(NODE_COUNT - 1);
    hang_node(root, root);
    members = {members, root};
    in_burst[root] = 1'b1;
    len = $urandom_range(6, 40);
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        if ($urandom_range(1)) ask_pair(any_placed(), any_placed());
        else hang_node(any_placed(), any_placed());
      end else if (roll < 55 && members.size() < NODE_COUNT / 2) begin
        do child = $urandom_range(NODE_COUNT - 1); while (in_burst[child]);
        // favour the newest member so that chains get deep
        if ($urandom_range(1)) parent = members[members.size() - 1];
        else parent = members[$urandom_range(members.size() - 1)];
        hang_node(child, parent);
        members = {members, child};
        in_burst[child] = 1'b1;
      end else begin
        ask_pair(members[$urandom_range(members.size() - 1)],
                 members[$urandom_range(members.size() - 1)]);
      end
    end
  endtask

  // a long chain of random nodes, queried end to end; then the root is hung
  // below the tail, which closes the chain into a cycle
  task automatic deep_chain();
    int order [NODE_COUNT];
    int pick, keep;
    foreach (order[n]) order[n] = n;
    for (int n = NODE_COUNT - 1; n > 0; n--) begin
      pick        = $urandom_range(n);
      keep        = order[n];
      order[n]    = order[pick];
      order[pick] = keep;
    end
    hang_node(order[0], order[0]);
    for (int n = 1; n < CHAIN_LEN; n++) hang_node(order[n], order[n-1]);
    ask_pair(order[CHAIN_LEN-1], order[0]);
    ask_pair(order[0], order[CHAIN_LEN-1]);
    repeat (10) ask_pair(order[$urandom_range(CHAIN_LEN - 1)],
                         order[$urandom_range(CHAIN_LEN - 1)]);
    // the chain turns into a cycle here
    hang_node(order[0], order[CHAIN_LEN-1]);
    ask_pair(order[0], order[CHAIN_LEN-1]);
    ask_pair(order[5], order[0]);
    hang_node(order[CHAIN_LEN-1], order[0]);
    repeat (6) ask_pair(order[$urandom_range(CHAIN_LEN - 1)],
                        order[$urandom_range(CHAIN_LEN - 1)]);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: sender rarely idle, receiver mostly stalled
    send_idle = 12;
    recv_idle = 80;

    // directed tree with the extreme node numbers and alternating bit patterns
    hang_node(1023, 1023);             // root at the top index
    hang_node(0, 1023);
    hang_node(341, 0);
    hang_node(682, 0);
    hang_node(512, 341);
    hang_node(1, 682);
    ask_pair(1023, 1023);              // same node, the root
    ask_pair(0, 1023);                 // ancestor against descendant
    ask_pair(512, 1);                  // cousins
    ask_pair(1, 512);                  // same pair swapped
    ask_pair(341, 682);                // siblings
    ask_pair(512, 512);
    // second root attach of an existing node leaves its subtree stale
    hang_node(682, 682);
    ask_pair(1, 512);
    // root hung below its own child: the ancestor found is deeper than both
    // nodes, so the distance comes out negative and is answered as zero
    hang_node(100, 100);
    hang_node(200, 100);
    hang_node(300, 100);
    hang_node(100, 200);
    ask_pair(200, 300);
    ask_pair(300, 100);

    // sender pauses until the block has answered everything
    settle_answers();

    target = 300;
    while (items_sent < target) tree_burst();
    settle_answers();

    // phase two: the other way round
    send_idle = 80;
    recv_idle = 12;
    target += 250;
    while (items_sent < target) tree_burst();
    settle_answers();

    // phase three: no idling at all
    send_idle = 0;
    recv_idle = 0;
    deep_chain();
    target = items_sent + 120;
    while (items_sent < target) tree_burst();

    settle_answers();
    repeat (QUERY_TAIL) @(posedge clk);
    if (model.answers_due.size() != 0)
      model.flag_mismatch($sformatf("%0d answers never came", model.answers_due.size()));
    if (model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
